[rtl/spi_nor_flash_command_sequencer_assert.svh]
// assertion macros shared by the sequencer checker
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SNFCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define SNFCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers the reset cycles
`define SNFCS_ASSERT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/snfcs_pkg.sv]
// types, codes and helpers of the spi nor flash command sequencer
package snfcs_pkg;

   // kind of input item
   typedef enum logic [1:0] {
      MODE_REQ = 2'd0,
      MODE_PAY = 2'd1,
      MODE_RX  = 2'd2
   } mode_type;

   // host commands
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_PROG  = 2'd1,
      CMD_ERASE = 2'd2,
      CMD_ID    = 2'd3
   } command_type;

   // result actions
   typedef enum logic [1:0] {
      ACT_XFER  = 2'd0,
      ACT_DESEL = 2'd1,
      ACT_DATA  = 2'd2,
      ACT_DONE  = 2'd3
   } action_type;

   // sequencer phases
   typedef enum logic [10:0] {
      PH_IDLE      = 11'b000_0000_0001,
      PH_POLL_CMD  = 11'b000_0000_0010,
      PH_POLL_STAT = 11'b000_0000_0100,
      PH_WREN      = 11'b000_0000_1000,
      PH_OPCODE    = 11'b000_0001_0000,
      PH_ADDR      = 11'b000_0010_0000,
      PH_READ      = 11'b000_0100_0000,
      PH_WAIT_PAY  = 11'b000_1000_0000,
      PH_PROG      = 11'b001_0000_0000,
      PH_ID_OP     = 11'b010_0000_0000,
      PH_ID_DATA   = 11'b100_0000_0000
   } phase_type;

   // flash opcodes
   localparam logic [7:0] OP_READ      = 8'h03;
   localparam logic [7:0] OP_PROG      = 8'h02;
   localparam logic [7:0] OP_ERASE     = 8'h20;
   localparam logic [7:0] OP_READ_ID   = 8'h9F;
   localparam logic [7:0] OP_WREN      = 8'h06;
   localparam logic [7:0] OP_READ_STAT = 8'h05;
   localparam logic [7:0] OP_DUMMY     = 8'h00;

   // queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // one result item
   typedef struct packed {
      action_type action;
      logic [7:0] transmit_byte;
      logic [7:0] read_byte;
      logic [7:0] maker_code;
      logic [7:0] part_code;
   } result_type;

   // all results of one input item, count from 1 to 3
   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] res;
   } bundle_type;

   // build a result item
   function automatic result_type mk_res(action_type a, logic [7:0] tx, logic [7:0] rd,
                                         logic [7:0] mk, logic [7:0] pc);
      result_type r;
      r.action        = a;
      r.transmit_byte = tx;
      r.read_byte     = rd;
      r.maker_code    = mk;
      r.part_code     = pc;
      return r;
   endfunction

   // opcode of a command
   function automatic logic [7:0] opcode_of(command_type c);
      logic [7:0] op;
      unique case (c)
         CMD_READ:  op = OP_READ;
         CMD_PROG:  op = OP_PROG;
         CMD_ERASE: op = OP_ERASE;
         CMD_ID:    op = OP_READ_ID;
         default:   op = OP_READ_ID;
      endcase
      return op;
   endfunction

endpackage

[rtl/spi_nor_flash_command_sequencer.sv]
// results of an accepted item are stored in the bundle queue and come out on rsp behind earlier bundles
// throughput: one item per cycle while the 4-bundle queue has room; one result per ready cycle
// each item yields up to three results, drained by the back walker one per rsp handshake
// reset: synchronous, active high; phase goes idle, state registers and queue are cleared
// top level of the spi nor flash command sequencer
module spi_nor_flash_command_sequencer #(
   parameter int PAGE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // mode
   // command, flash_address, byte_count, payload_byte, received_byte, zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,  // action
   output logic        rsp_tlast,
   // transmit_byte, read_byte, maker_code, part_code
   output logic [31:0] rsp_tdata
);

   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_empty;
   snfcs_pkg::bundle_type q_bundle;
   snfcs_pkg::bundle_type q_head;
   snfcs_pkg::result_type res;

   // command state machine
   snfcs_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tuser),
      .in_command  (req_tdata[1:0]),
      .in_address  (req_tdata[25:2]),
      .in_count    (req_tdata[48:26]),
      .in_payload  (req_tdata[56:49]),
      .in_received (req_tdata[64:57]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_bundle    (q_bundle)
   );

   // bundle queue
   snfcs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (q_bundle),
      .full        (q_full),
      .pop         (q_pop),
      .empty       (q_empty),
      .head        (q_head)
   );

   // result walker
   snfcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (q_head),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res),
      .out_last  (rsp_tlast)
   );

   // result packing
   assign rsp_tuser = res.action;
   assign rsp_tdata = {res.part_code, res.maker_code, res.read_byte, res.transmit_byte};

endmodule

[rtl/snfcs_front.sv]
// front: accepts input items, runs the command state machine, builds result bundles
module snfcs_front #(
   parameter int PAGE_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [1:0]             in_mode,
   input  logic [1:0]             in_command,
   input  logic [23:0]            in_address,
   input  logic [22:0]            in_count,
   input  logic [7:0]             in_payload,
   input  logic [7:0]             in_received,
   input  logic                   q_full,
   output logic                   q_push,
   output snfcs_pkg::bundle_type  q_bundle
);

   localparam logic [22:0] PageLimit = 23'(PAGE_BYTES);

   snfcs_pkg::phase_type   phase_ff, phase_in;
   snfcs_pkg::command_type cmd_ff, cmd_in;
   logic [23:0]            addr_ff, addr_in;
   logic [22:0]            left_ff, left_in;
   logic [1:0]             hidx_ff, hidx_in;
   logic [7:0]             maker_ff, maker_in;
   logic                   final_ff, final_in;

   logic                   fire;
   logic [1:0]             n;
   logic [22:0]            cnt_sat;
   snfcs_pkg::command_type req_cmd;

   assign in_ready = !q_full;
   assign fire     = in_valid && in_ready;
   assign req_cmd  = snfcs_pkg::command_type'(in_command);

   // program length saturates at one page
   always_comb begin
      if (req_cmd == snfcs_pkg::CMD_PROG && in_count > PageLimit) begin
         cnt_sat = PageLimit;
      end else begin
         cnt_sat = in_count;
      end
   end

   // next state and result bundle
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      hidx_in  = hidx_ff;
      maker_in = maker_ff;
      final_in = final_ff;
      n        = 2'd0;
      q_bundle = '0;
      if (fire) begin
         unique case (snfcs_pkg::mode_type'(in_mode))
            snfcs_pkg::MODE_REQ: begin
               if (phase_ff == snfcs_pkg::PH_IDLE) begin
                  cmd_in   = req_cmd;
                  addr_in  = in_address;
                  hidx_in  = 2'd0;
                  final_in = 1'b0;
                  left_in  = cnt_sat;
                  if (req_cmd == snfcs_pkg::CMD_ID) begin
                     phase_in = snfcs_pkg::PH_ID_OP;
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                        snfcs_pkg::OP_READ_ID, 8'd0, 8'd0, 8'd0);
                  end else begin
                     phase_in = snfcs_pkg::PH_POLL_CMD;
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                        snfcs_pkg::OP_READ_STAT, 8'd0, 8'd0, 8'd0);
                  end
                  n = n + 2'd1;
               end
            end
            snfcs_pkg::MODE_PAY: begin
               if (phase_ff == snfcs_pkg::PH_WAIT_PAY) begin
                  phase_in = snfcs_pkg::PH_PROG;
                  q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                     in_payload, 8'd0, 8'd0, 8'd0);
                  n = n + 2'd1;
               end
            end
            snfcs_pkg::MODE_RX: begin
               unique case (phase_ff)
                  snfcs_pkg::PH_POLL_CMD: begin
                     phase_in = snfcs_pkg::PH_POLL_STAT;
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                        snfcs_pkg::OP_DUMMY, 8'd0, 8'd0, 8'd0);
                     n = n + 2'd1;
                  end
                  snfcs_pkg::PH_POLL_STAT: begin
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                        8'd0, 8'd0, 8'd0, 8'd0);
                     n = n + 2'd1;
                     priority if (in_received[0]) begin
                        phase_in = snfcs_pkg::PH_POLL_CMD;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_READ_STAT, 8'd0, 8'd0, 8'd0);
                     end else if (final_ff) begin
                        phase_in = snfcs_pkg::PH_IDLE;
                        final_in = 1'b0;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DONE,
                           8'd0, 8'd0, 8'd0, 8'd0);
                     end else if (cmd_ff == snfcs_pkg::CMD_READ) begin
                        phase_in = snfcs_pkg::PH_OPCODE;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
                     end else begin
                        phase_in = snfcs_pkg::PH_WREN;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_WREN, 8'd0, 8'd0, 8'd0);
                     end
                     n = n + 2'd1;
                  end
                  snfcs_pkg::PH_WREN: begin
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                        8'd0, 8'd0, 8'd0, 8'd0);
                     n = n + 2'd1;
                     phase_in = snfcs_pkg::PH_OPCODE;
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                        snfcs_pkg::opcode_of(cmd_ff), 8'd0, 8'd0, 8'd0);
                     n = n + 2'd1;
                  end
                  snfcs_pkg::PH_OPCODE: begin
                     phase_in = snfcs_pkg::PH_ADDR;
                     hidx_in  = 2'd0;
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                        addr_ff[23:16], 8'd0, 8'd0, 8'd0);
                     n = n + 2'd1;
                  end
                  snfcs_pkg::PH_ADDR: begin
                     priority if (hidx_ff == 2'd0) begin
                        hidx_in = 2'd1;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           addr_ff[15:8], 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                     end else if (hidx_ff == 2'd1) begin
                        hidx_in = 2'd2;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           addr_ff[7:0], 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                     end else if (cmd_ff == snfcs_pkg::CMD_READ) begin
                        if (left_ff == 23'd0) begin
                           q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                              8'd0, 8'd0, 8'd0, 8'd0);
                           n = n + 2'd1;
                           phase_in = snfcs_pkg::PH_IDLE;
                           final_in = 1'b0;
                           q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DONE,
                              8'd0, 8'd0, 8'd0, 8'd0);
                           n = n + 2'd1;
                        end else begin
                           phase_in = snfcs_pkg::PH_READ;
                           q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                              snfcs_pkg::OP_DUMMY, 8'd0, 8'd0, 8'd0);
                           n = n + 2'd1;
                        end
                     end else if (cmd_ff == snfcs_pkg::CMD_PROG && left_ff != 23'd0) begin
                        phase_in = snfcs_pkg::PH_WAIT_PAY;
                     end else begin
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                           8'd0, 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                        final_in = 1'b1;
                        phase_in = snfcs_pkg::PH_POLL_CMD;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_READ_STAT, 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                     end
                  end
                  snfcs_pkg::PH_READ: begin
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DATA,
                        8'd0, in_received, 8'd0, 8'd0);
                     n = n + 2'd1;
                     left_in = left_ff - 23'd1;
                     if (left_ff == 23'd1) begin
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                           8'd0, 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                        phase_in = snfcs_pkg::PH_IDLE;
                        final_in = 1'b0;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DONE,
                           8'd0, 8'd0, 8'd0, 8'd0);
                     end else begin
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_DUMMY, 8'd0, 8'd0, 8'd0);
                     end
                     n = n + 2'd1;
                  end
                  snfcs_pkg::PH_PROG: begin
                     left_in = left_ff - 23'd1;
                     if (left_ff == 23'd1) begin
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                           8'd0, 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                        final_in = 1'b1;
                        phase_in = snfcs_pkg::PH_POLL_CMD;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_READ_STAT, 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                     end else begin
                        phase_in = snfcs_pkg::PH_WAIT_PAY;
                     end
                  end
                  snfcs_pkg::PH_ID_OP: begin
                     phase_in = snfcs_pkg::PH_ID_DATA;
                     hidx_in  = 2'd0;
                     q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                        snfcs_pkg::OP_DUMMY, 8'd0, 8'd0, 8'd0);
                     n = n + 2'd1;
                  end
                  snfcs_pkg::PH_ID_DATA: begin
                     priority if (hidx_ff == 2'd0) begin
                        maker_in = in_received;
                        hidx_in  = 2'd1;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_DUMMY, 8'd0, 8'd0, 8'd0);
                     end else if (hidx_ff == 2'd1) begin
                        hidx_in = 2'd2;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_XFER,
                           snfcs_pkg::OP_DUMMY, 8'd0, 8'd0, 8'd0);
                     end else begin
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DESEL,
                           8'd0, 8'd0, 8'd0, 8'd0);
                        n = n + 2'd1;
                        phase_in = snfcs_pkg::PH_IDLE;
                        final_in = 1'b0;
                        q_bundle.res[n] = snfcs_pkg::mk_res(snfcs_pkg::ACT_DONE,
                           8'd0, 8'd0, maker_ff, in_received);
                     end
                     n = n + 2'd1;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      q_bundle.count = n;
   end

   // a bundle goes to the queue only when the item caused results
   assign q_push = fire && (n != 2'd0);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= snfcs_pkg::PH_IDLE;
         cmd_ff   <= snfcs_pkg::CMD_READ;
         addr_ff  <= '0;
         left_ff  <= '0;
         hidx_ff  <= '0;
         maker_ff <= '0;
         final_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
         hidx_ff  <= hidx_in;
         maker_ff <= maker_in;
         final_ff <= final_in;
      end
   end

endmodule

[rtl/snfcs_queue.sv]
// short queue of result bundles between front and back
module snfcs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  snfcs_pkg::bundle_type push_bundle,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output snfcs_pkg::bundle_type head
);

   localparam int CntW = $clog2(snfcs_pkg::QueueDepth + 1);

   snfcs_pkg::bundle_type            slot_ff [snfcs_pkg::QueueDepth];
   logic [snfcs_pkg::QueuePtrW-1:0]  wr_ff, wr_in;
   logic [snfcs_pkg::QueuePtrW-1:0]  rd_ff, rd_in;
   logic [CntW-1:0]                  cnt_ff, cnt_in;

   assign full  = (cnt_ff == CntW'(snfcs_pkg::QueueDepth));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_bundle;
      end
   end

endmodule

[rtl/snfcs_back.sv]
// back: walks the head bundle and hands out one result item per handshake
module snfcs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  snfcs_pkg::bundle_type head,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output snfcs_pkg::result_type out_res,
   output logic                  out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       fire;

   assign out_valid = !empty;
   assign out_res   = head.res[idx_ff];
   assign out_last  = (idx_ff == head.count - 2'd1);
   assign fire      = out_valid && out_ready;
   assign pop       = fire && out_last;

   // position inside the head bundle
   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = 2'd0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[rtl/snfcs_checker.sv]
// port checker for the sequencer result channel, bound to the top level
`include "spi_nor_flash_command_sequencer_assert.svh"

module snfcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic [31:0] rsp_tdata
);

   // no result item right after reset
   `SNFCS_ASSERT_RST(a_reset_quiet, clock, reset, !rsp_tvalid, "result valid after reset")

   // a done item always closes the results of its input item
   `SNFCS_ASSERT_IMP(a_done_last, clock, reset,
      rsp_tvalid && rsp_tuser == snfcs_pkg::ACT_DONE, rsp_tlast, "done without last")

   // deselect and read data are always followed by another item of the same input
   `SNFCS_ASSERT_IMP(a_mid_not_last, clock, reset,
      rsp_tvalid && (rsp_tuser == snfcs_pkg::ACT_DESEL || rsp_tuser == snfcs_pkg::ACT_DATA),
      !rsp_tlast, "deselect or read data marked last")

   // stalled result holds
   `SNFCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result changed")

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (.*);
